@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/imad_pkg.sv @@
// Types and constants of the IMA ADPCM nibble decoder.
package imad_pkg;

   localparam int unsigned StepCount = 89;

   localparam logic [6:0] MaxStepIndex = 7'd88;

   localparam logic signed [15:0] SampleMax = 16'sh7fff;
   localparam logic signed [15:0] SampleMin = 16'sh8001;
   localparam logic signed [17:0] SumMax    = 18'sd32767;
   localparam logic signed [17:0] SumMin    = -18'sd32767;

   localparam logic MODE_HEADER = 1'b0;
   localparam logic MODE_DATA   = 1'b1;

   localparam logic [14:0] StepTable [StepCount] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
      15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
      15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
      15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
      15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
      15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
      15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
      15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
      15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
      15'd32767
   };

   typedef struct packed {
      logic signed [15:0] predictor;
      logic [6:0]         step_index;
   } dec_state_type;

endpackage

@@ rtl/core/imad_if.sv @@
// Request and response channel interfaces of the IMA ADPCM nibble decoder.
interface imad_req_if;
   logic              valid;
   logic              ready;
   logic              mode;
   logic signed [15:0] init_predictor;
   logic [7:0]        init_step_index;
   logic [7:0]        data_byte;
   logic              last_byte;

   modport source (
      output valid, mode, init_predictor, init_step_index, data_byte, last_byte,
      input  ready
   );
   modport sink (
      input  valid, mode, init_predictor, init_step_index, data_byte, last_byte,
      output ready
   );
endinterface

interface imad_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] sample;
   logic              last_of_pair;
   logic              block_end;

   modport source (
      output valid, sample, last_of_pair, block_end,
      input  ready
   );
   modport sink (
      input  valid, sample, last_of_pair, block_end,
      output ready
   );
endinterface

@@ rtl/core/imad_nibble_dec.sv @@
// One-code IMA ADPCM decode step: step lookup, difference, saturation, index update.
module imad_nibble_dec import imad_pkg::*; (
   input  dec_state_type cur_state,
   input  logic [3:0]    code,
   output dec_state_type next_state
);

   logic [14:0]        step;
   logic [16:0]        step_ext;
   logic [16:0]        diff;
   logic signed [17:0] pred_ext;
   logic signed [17:0] diff_ext;
   logic signed [17:0] sum_add;
   logic signed [17:0] sum_sub;
   logic [7:0]         idx_adj;
   logic [7:0]         idx_up;

   assign step     = StepTable[cur_state.step_index];
   assign step_ext = {2'b00, step};

   always_comb begin
      diff = step_ext >> 3;
      if (code[2]) begin
         diff = diff + step_ext;
      end
      if (code[1]) begin
         diff = diff + (step_ext >> 1);
      end
      if (code[0]) begin
         diff = diff + (step_ext >> 2);
      end
   end

   assign pred_ext = {{2{cur_state.predictor[15]}}, cur_state.predictor};
   assign diff_ext = $signed({1'b0, diff});
   assign sum_add  = pred_ext + diff_ext;
   assign sum_sub  = pred_ext - diff_ext;

   assign idx_adj = ({6'b000000, code[1:0]} + 8'd1) << 1;
   assign idx_up  = {1'b0, cur_state.step_index} + idx_adj;

   always_comb begin
      // Each direction clamps only on its own side, so a predictor of -32768
      // can survive an add of zero.
      if (code[3]) begin
         next_state.predictor = (sum_sub < SumMin) ? SampleMin : sum_sub[15:0];
      end else begin
         next_state.predictor = (sum_add > SumMax) ? SampleMax : sum_add[15:0];
      end

      if (code[2]) begin
         next_state.step_index = (idx_up > {1'b0, MaxStepIndex}) ? MaxStepIndex
                                                                 : idx_up[6:0];
      end else begin
         next_state.step_index = (cur_state.step_index == 7'd0) ? 7'd0
                                                                : cur_state.step_index - 7'd1;
      end
   end

endmodule

@@ rtl/core/ima_adpcm_nibble_decoder.sv @@
// Top level of the IMA ADPCM nibble decoder.
//
//   channel  | dir | carries                                             | per request
//   req_ch   | in  | mode, init_predictor, init_step_index, data_byte,   | one item
//            |     | last_byte                                           |
//   rsp_ch   | out | sample, last_of_pair, block_end                     | 0 or 2 items
//
// A data request is decoded one nibble per cycle while the response is not stalled, through a single
// step-table lookup and saturating add, and the two samples leave one per cycle when the receiver is ready.
// A header request produces no response.
// The next request is accepted in the cycle the high nibble is decoded, so a new
// byte is taken before the last sample of the previous one has left. A stalled response
// holds the decoder; the registered response stage decouples the two sides. Reset clears
// the predictor and step index to zero and empties both stages.
`include "assert_macros.svh"

module ima_adpcm_nibble_decoder import imad_pkg::*; (
   input logic         clock,
   input logic         reset,
   imad_req_if.sink    req_ch,
   imad_rsp_if.source  rsp_ch
);

   dec_state_type state_ff, state_in;
   dec_state_type dec_next;

   logic        hold_valid_ff, hold_valid_in;
   logic        hold_phase_ff, hold_phase_in;
   logic [7:0]  hold_byte_ff, hold_byte_in;
   logic        hold_last_ff, hold_last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_end_ff, rsp_end_in;

   logic       fire;
   logic       req_accept;
   logic [3:0] code;

   assign fire       = hold_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign code       = hold_phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];
   assign req_ch.ready = !hold_valid_ff || (fire && hold_phase_ff);
   assign req_accept = req_ch.valid && req_ch.ready;

   imad_nibble_dec u_dec (
      .cur_state  (state_ff),
      .code       (code),
      .next_state (dec_next)
   );

   always_comb begin
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      hold_phase_in = hold_phase_ff;
      hold_byte_in  = hold_byte_ff;
      hold_last_in  = hold_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;

      if (fire) begin
         state_in      = dec_next;
         rsp_valid_in  = 1'b1;
         rsp_sample_in = dec_next.predictor;
         rsp_last_in   = hold_phase_ff;
         rsp_end_in    = hold_phase_ff && hold_last_ff;
         if (hold_phase_ff) begin
            hold_valid_in = 1'b0;
         end else begin
            hold_phase_in = 1'b1;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // A header request in the same cycle as the final decode is the later item, so it wins.
      if (req_accept) begin
         if (req_ch.mode == MODE_HEADER) begin
            state_in.predictor  = req_ch.init_predictor;
            state_in.step_index = (req_ch.init_step_index > {1'b0, MaxStepIndex})
                                  ? MaxStepIndex : req_ch.init_step_index[6:0];
         end else begin
            hold_valid_in = 1'b1;
            hold_phase_in = 1'b0;
            hold_byte_in  = req_ch.data_byte;
            hold_last_in  = req_ch.last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         hold_valid_ff <= 1'b0;
         hold_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         hold_phase_ff <= hold_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff  <= hold_byte_in;
      hold_last_ff  <= hold_last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.sample       = rsp_sample_ff;
   assign rsp_ch.last_of_pair = rsp_last_ff;
   assign rsp_ch.block_end    = rsp_end_ff;

   `ASSERT_ALWAYS(a_step_index_range, clock, reset, state_ff.step_index <= MaxStepIndex, "step index above 88")
   `ASSERT_IMPLIES(a_low_nibble_pending, clock, reset, rsp_valid_ff && !rsp_last_ff, hold_valid_ff && hold_phase_ff, "low-nibble sample without pending high nibble")
   `ASSERT_IMPLIES(a_block_end_on_last, clock, reset, rsp_valid_ff && rsp_end_ff, rsp_last_ff, "block end on a low-nibble sample")
   `ASSERT_IMPLIES(a_accept_when_free, clock, reset, req_accept && hold_valid_ff, fire && hold_phase_ff, "request accepted while a byte is still being decoded")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for the IMA ADPCM nibble decoder: directed table, random blocks, scoreboard.
module testbench;
   import imad_pkg::*;

   localparam int ClockHigh      = 5;
   localparam int ClockLow       = 5;
   localparam int ItemsPerPhase  = 340;
   localparam int HoldOffCycles  = 300;
   localparam int WatchdogLimit  = 3000;
   localparam int DrainCycles    = 20;
   localparam int MaxReported    = 10;
   localparam int DirectedCount  = 22;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] init_predictor;
      logic [7:0]         init_step_index;
      logic [7:0]         data_byte;
      logic               last_byte;
   } adpcm_request_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_of_pair;
      logic               block_end;
   } pcm_sample_type;

   typedef struct packed {
      adpcm_request_type  request;
      logic               typed;
      logic signed [15:0] low_sample;
      logic signed [15:0] high_sample;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imad_req_if req_ch ();
   imad_rsp_if rsp_ch ();

   ima_adpcm_nibble_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #ClockHigh clock = 1'b1;
      #ClockLow  clock = 1'b0;
   end

   // Decoder state as the scoreboard sees it.
   logic signed [15:0] decoded_sample = '0;
   logic [6:0]         decoded_index  = '0;
   pcm_sample_type     expected_samples [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   bit hold_served    = 1'b0;
   int hold_left      = 0;

   int error_count    = 0;
   int header_count   = 0;
   int data_count     = 0;
   int sample_count   = 0;
   int clipped_count  = 0;
   int idle_cycles    = 0;

   directed_row_type directed_rows [DirectedCount] = '{
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h00, 1'b0}, 1'b1, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h77, 1'b1}, 1'b1, 16'sd11,     16'sd41},
      '{'{MODE_HEADER,  16'sd32767,  8'd255, 8'hA5, 1'b1}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,   -16'sd1234,   8'd200, 8'h07, 1'b1}, 1'b1, 16'sd32767,  16'sd32767},
      '{'{MODE_HEADER, -16'sd32768,  8'd89,  8'h3C, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'hFF, 1'b0}, 1'b1, -16'sd32767, -16'sd32767},
      '{'{MODE_HEADER, -16'sd32768,  8'd88,  8'h00, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h08, 1'b1}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_HEADER,  16'sd0,      8'd0,   8'h00, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h10, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h32, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h54, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h76, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h98, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'hBA, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'hDC, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'hFE, 1'b1}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_HEADER,  16'sd0,      8'd88,  8'h00, 1'b0}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h77, 1'b0}, 1'b1, 16'sd32767,  16'sd32767},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'hFF, 1'b1}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_HEADER, -16'sd1,      8'd0,   8'hFF, 1'b1}, 1'b0, 16'sd0,      16'sd0},
      '{'{MODE_DATA,    16'sd0,      8'd0,   8'h9A, 1'b1}, 1'b0, 16'sd0,      16'sd0}
   };

   // Decodes one 4-bit code against the tracked state and advances it.
   function automatic logic signed [15:0] decode_nibble(input logic [3:0] code);
      int step;
      int delta;
      int total;
      int next_index;
      step  = int'(StepTable[decoded_index]);
      delta = step >>> 3;
      if (code[2]) delta += step;
      if (code[1]) delta += step >>> 1;
      if (code[0]) delta += step >>> 2;
      next_index = int'(decoded_index) + (code[2] ? 2 * (int'(code[1:0]) + 1) : -1);
      if (next_index < 0) next_index = 0;
      if (next_index > int'(MaxStepIndex)) next_index = int'(MaxStepIndex);
      decoded_index = next_index[6:0];
      total = int'(decoded_sample);
      if (code[3]) begin
         if (total < -32767 + delta) begin
            total = -32767;
            clipped_count++;
         end else begin
            total -= delta;
         end
      end else begin
         if (total > 32767 - delta) begin
            total = 32767;
            clipped_count++;
         end else begin
            total += delta;
         end
      end
      decoded_sample = total[15:0];
      return decoded_sample;
   endfunction

   // Updates the tracked state for an accepted request and queues its samples.
   task automatic predict_samples(input adpcm_request_type r, input logic typed,
                                  input logic signed [15:0] low_val,
                                  input logic signed [15:0] high_val);
      logic signed [15:0] low_pcm;
      logic signed [15:0] high_pcm;
      if (r.mode == MODE_HEADER) begin
         decoded_sample = r.init_predictor;
         decoded_index  = (r.init_step_index > 8'(MaxStepIndex)) ? MaxStepIndex
                                                                 : r.init_step_index[6:0];
         header_count++;
      end else begin
         low_pcm  = decode_nibble(r.data_byte[3:0]);
         high_pcm = decode_nibble(r.data_byte[7:4]);
         if (typed) begin
            low_pcm  = low_val;
            high_pcm = high_val;
         end
         expected_samples.push_back('{low_pcm, 1'b0, 1'b0});
         expected_samples.push_back('{high_pcm, 1'b1, r.last_byte});
         data_count++;
      end
   endtask

   // Offers one request after a random gap and returns once it is accepted.
   task automatic send_request(input adpcm_request_type r, input logic typed,
                               input logic signed [15:0] low_val,
                               input logic signed [15:0] high_val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.mode            <= r.mode;
      req_ch.init_predictor  <= r.init_predictor;
      req_ch.init_step_index <= r.init_step_index;
      req_ch.data_byte       <= r.data_byte;
      req_ch.last_byte       <= r.last_byte;
      do @(posedge clock); while (!req_ch.ready);
      predict_samples(r, typed, low_val, high_val);
   endtask

   function automatic adpcm_request_type random_request(input logic mode, input logic last);
      adpcm_request_type r;
      r.mode            = mode;
      r.init_predictor  = 16'($urandom);
      r.init_step_index = ($urandom_range(99) < 85) ? 8'($urandom_range(88))
                                                    : 8'($urandom_range(255, 89));
      r.data_byte       = 8'($urandom);
      r.last_byte       = last;
      return r;
   endfunction

   // Mostly well-formed blocks (header then data bytes), with some loose requests mixed in.
   task automatic run_random_phase(input int count);
      int sent;
      int block_len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 10) begin
            send_request(random_request(1'($urandom), 1'($urandom)), 1'b0, '0, '0);
            sent++;
         end else begin
            send_request(random_request(MODE_HEADER, 1'($urandom)), 1'b0, '0, '0);
            block_len = $urandom_range(12, 1);
            for (int i = 0; i < block_len; i++) begin
               send_request(random_request(MODE_DATA, i == block_len - 1), 1'b0, '0, '0);
            end
            sent += block_len + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_request && !hold_served) begin
         hold_served  <= 1'b1;
         hold_left    <= HoldOffCycles;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      pcm_sample_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sample_count++;
         if (expected_samples.size() == 0) begin
            error_count++;
            if (error_count <= MaxReported)
               $display("ERROR: unexpected sample %0d last_of_pair=%b block_end=%b",
                        rsp_ch.sample, rsp_ch.last_of_pair, rsp_ch.block_end);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_ch.sample !== want.sample || rsp_ch.last_of_pair !== want.last_of_pair ||
                rsp_ch.block_end !== want.block_end) begin
               error_count++;
               if (error_count <= MaxReported)
                  $display("ERROR: sample %0d: expected %0d/%b/%b, got %0d/%b/%b",
                           sample_count, want.sample, want.last_of_pair, want.block_end,
                           rsp_ch.sample, rsp_ch.last_of_pair, rsp_ch.block_end);
            end
         end
      end
   end

   // Ends the run when neither channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("ERROR: no progress for %0d cycles", WatchdogLimit);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.mode            = MODE_HEADER;
      req_ch.init_predictor  = '0;
      req_ch.init_step_index = '0;
      req_ch.data_byte       = '0;
      req_ch.last_byte       = 1'b0;
      rsp_ch.ready           = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].request, directed_rows[i].typed,
                      directed_rows[i].low_sample, directed_rows[i].high_sample);
      end

      run_random_phase(ItemsPerPhase);
      send_idle_pct = 80;
      run_random_phase(ItemsPerPhase);
      send_idle_pct  = 0;
      recv_stall_pct = 80;
      run_random_phase(ItemsPerPhase);
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      run_random_phase(ItemsPerPhase);

      // The receiver holds off for a long stretch while requests keep coming.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 1'b1;
      run_random_phase(ItemsPerPhase);

      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      error_count += expected_samples.size();

      $display("Covered %0d header and %0d data requests, %0d samples checked (%0d clipped).",
               header_count, data_count, sample_count, clipped_count);
      $display("Idle phases: none, sender 80%%, receiver 80%%, both 15%%, long receiver hold-off.");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in total", error_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
